[rtl/core/esla_pkg.sv]
// shared types and constants for the escape stripping line assembler
package esla_pkg;

    localparam int LINE_BYTES_DEFAULT = 64;

    localparam logic [7:0] CHAR_NUL      = 8'h00;
    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_ESC      = 8'h1B;
    localparam logic [7:0] CHAR_AT       = 8'h40;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_TILDE    = 8'h7E;

    localparam logic [1:0] ESC_PLAIN = 2'd0;
    localparam logic [1:0] ESC_SEEN  = 2'd1;
    localparam logic [1:0] ESC_CSI   = 2'd2;

    typedef struct packed {
        logic text;
        logic newline;
        logic backspace;
    } esla_action_t;

endpackage

[rtl/core/esla_filter.sv]
// escape sequence tracker and character classifier
module esla_filter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            char_in,
    input  logic                  accept,
    output esla_pkg::esla_action_t action
);

    logic [1:0] escape_mode_reg;
    logic [1:0] escape_mode_next;

    always_comb
    begin
        escape_mode_next = escape_mode_reg;
        action           = '0;
        case (escape_mode_reg)
            esla_pkg::ESC_SEEN:
            begin
                escape_mode_next = (char_in == esla_pkg::CHAR_LBRACKET) ?
                                   esla_pkg::ESC_CSI : esla_pkg::ESC_PLAIN;
            end
            esla_pkg::ESC_CSI:
            begin
                if (char_in inside {[esla_pkg::CHAR_AT:esla_pkg::CHAR_TILDE]})
                begin
                    escape_mode_next = esla_pkg::ESC_PLAIN;
                end
            end
            default:
            begin
                escape_mode_next = esla_pkg::ESC_PLAIN;
                if (char_in == esla_pkg::CHAR_ESC)
                begin
                    escape_mode_next = esla_pkg::ESC_SEEN;
                end
                else if (char_in == esla_pkg::CHAR_LF)
                begin
                    action.newline = 1'b1;
                end
                else if (char_in inside {esla_pkg::CHAR_CR, esla_pkg::CHAR_NUL})
                begin
                    action = '0;
                end
                else if (char_in == esla_pkg::CHAR_BS)
                begin
                    action.backspace = 1'b1;
                end
                else
                begin
                    action.text = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_mode_reg <= esla_pkg::ESC_PLAIN;
        end
        else if (accept)
        begin
            escape_mode_reg <= escape_mode_next;
        end
    end

endmodule

[rtl/core/escape_stripping_line_assembler.sv]
// top level: console byte filter and line buffer with line readout
// Takes one console byte per cycle while no line is being read out; escape
// sequences, carriage return and NUL are dropped, backspace removes the last
// stored byte. A newline, or a text byte that meets a full line store, starts
// readout of the stored line: the single read port of the line store takes a new
// read only when no read is pending and the output register is free or being
// emptied, and in_ready stays low until the last byte reaches the output register.
// The last byte may still wait there while the next input bytes are taken.
module escape_stripping_line_assembler
#(
    parameter int LINE_BYTES = esla_pkg::LINE_BYTES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       line_last
);

    localparam int LEN_W = $clog2(LINE_BYTES);
    localparam logic [LEN_W-1:0] LAST_LEN = LEN_W'(LINE_BYTES - 1);
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic [7:0] line_store_mem [LINE_BYTES];

    logic             state_reg, state_next;
    logic             capture_enable_reg, capture_enable_next;
    logic [LEN_W-1:0] line_length_reg, line_length_next;
    logic [LEN_W-1:0] rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0] last_idx_reg, last_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_pending_reg, rd_pending_next;
    logic             rd_last_reg, rd_last_next;
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       line_byte_reg;
    logic             line_last_reg;

    esla_pkg::esla_action_t action;
    logic accept;
    logic act_en;
    logic full;
    logic start_emit;
    logic store;
    logic issue;
    logic issue_last;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign line_last = line_last_reg;

    assign accept = in_valid & in_ready;
    assign act_en = accept & capture_enable_reg;

    esla_filter u_filter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .accept  (act_en),
        .action  (action)
    );

    assign full       = (line_length_reg == LAST_LEN);
    assign start_emit = act_en & ((action.newline & (line_length_reg != '0)) |
                                  (action.text & full));
    assign store      = act_en & action.text & ~full;
    assign issue      = (state_reg == ST_DRAIN) & ~issue_done_reg & ~rd_pending_reg &
                        (~out_valid_reg | out_ready);
    assign issue_last = (rd_idx_reg == last_idx_reg);

    always_comb
    begin
        state_next          = state_reg;
        capture_enable_next = capture_enable_reg;
        line_length_next    = line_length_reg;
        rd_idx_next         = rd_idx_reg;
        last_idx_next       = last_idx_reg;
        issue_done_next     = issue_done_reg;
        rd_pending_next     = rd_pending_reg;
        rd_last_next        = rd_last_reg;
        out_valid_next      = out_valid_reg;

        if (cfg_valid)
        begin
            capture_enable_next = cfg_data;
        end

        if (state_reg == ST_IDLE)
        begin
            if (start_emit)
            begin
                state_next       = ST_DRAIN;
                rd_idx_next      = '0;
                last_idx_next    = line_length_reg - 1'b1;
                issue_done_next  = 1'b0;
                line_length_next = '0;
            end
            else if (store)
            begin
                line_length_next = line_length_reg + 1'b1;
            end
            else if (act_en & action.backspace & (line_length_reg != '0))
            begin
                line_length_next = line_length_reg - 1'b1;
            end
        end

        if (issue)
        begin
            rd_idx_next     = rd_idx_reg + 1'b1;
            rd_pending_next = 1'b1;
            rd_last_next    = issue_last;
            issue_done_next = issue_last;
        end

        // read data passes through rd_data_reg into the output register
        if (rd_pending_reg)
        begin
            rd_pending_next = 1'b0;
            out_valid_next  = 1'b1;
            if (rd_last_reg)
            begin
                state_next = ST_IDLE;
            end
        end
        else if (out_valid_reg & out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            capture_enable_reg <= 1'b0;
            line_length_reg    <= '0;
            rd_idx_reg         <= '0;
            last_idx_reg       <= '0;
            issue_done_reg     <= 1'b1;
            rd_pending_reg     <= 1'b0;
            rd_last_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            capture_enable_reg <= capture_enable_next;
            line_length_reg    <= line_length_next;
            rd_idx_reg         <= rd_idx_next;
            last_idx_reg       <= last_idx_next;
            issue_done_reg     <= issue_done_next;
            rd_pending_reg     <= rd_pending_next;
            rd_last_reg        <= rd_last_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            line_store_mem[line_length_reg] <= char_in;
        end
        if (issue)
        begin
            rd_data_reg <= line_store_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pending_reg)
        begin
            line_byte_reg <= rd_data_reg;
            line_last_reg <= rd_last_reg;
        end
    end

endmodule

[rtl/core/esla_checker.sv]
// port level checks for the escape stripping line assembler
module esla_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] line_byte,
    input logic       line_last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_byte) && $stable(line_last))
    else $error("stalled result changed");

    // input held off while a line is still being read out
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_last |-> !in_ready)
    else $error("input taken during line readout");

    // within a line, out_valid drops after each transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !line_last |=> !out_valid)
    else $error("readout faster than the line store allows");

    // after a non-last transfer the line is still in readout
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !line_last |=> !in_ready)
    else $error("readout ended before the last byte");

endmodule

bind escape_stripping_line_assembler esla_checker u_esla_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .line_byte (line_byte),
    .line_last (line_last)
);
